### sv/space_to_tab_entab_assert.svh
// Assertion macros for the entab RTL; the result queue (ste_outq) uses them.
`ifndef SPACE_TO_TAB_ENTAB_ASSERT_SVH
`define SPACE_TO_TAB_ENTAB_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define STE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define STE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STE_ASSERT(lbl, prop, msg)
`define STE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/ste_pkg.sv
// Types and constants for the space-to-tab entab block.
package ste_pkg;

  localparam int MAX_STOPS        = 4;
  localparam int NUM_STOP_REGS    = 4;
  localparam int USABLE_MAX       = (MAX_STOPS < NUM_STOP_REGS) ? MAX_STOPS : NUM_STOP_REGS;
  localparam int OUTQ_DEPTH       = 4;

  localparam logic [7:0]  DEF_COL_WIDTH    = 8'd4;
  localparam logic [2:0]  DEFAULT_STOP_CNT = 3'd1;
  localparam logic [15:0] DEFAULT_STOP_0   = 16'd5;
  localparam logic [15:0] DEFAULT_STOP_1   = 16'd9;
  localparam logic [15:0] DEFAULT_STOP_2   = 16'd13;
  localparam logic [15:0] DEFAULT_STOP_3   = 16'd17;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Configuration register indexes
  localparam logic [2:0] REG_COL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_STOP_COUNT = 3'd1;
  localparam logic [2:0] REG_STOP_0     = 3'd2;
  localparam logic [2:0] REG_STOP_1     = 3'd3;
  localparam logic [2:0] REG_STOP_2     = 3'd4;
  localparam logic [2:0] REG_STOP_3     = 3'd5;

  localparam int RES_W = 25;

  typedef struct packed {
    logic        last;
    logic [15:0] cnt;
    logic [7:0]  ch;
  } res_t;

  // Up to two results per input byte, already compacted into slot 0 first.
  typedef struct packed {
    logic [1:0] num;
    res_t       r1;
    res_t       r0;
  } res_pair_t;

endpackage

### sv/ste_core.sv
// Column tracking, tab stop selection and result generation for one byte.
module ste_core
  import ste_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        step_en,
  input  logic [7:0]  step_byte,
  output res_pair_t   step_res
);

  logic [7:0]  column_width_r;
  logic [2:0]  stop_count_r;
  logic [15:0] stops_r [NUM_STOP_REGS];

  logic [15:0] column_r, column_nxt;
  logic [15:0] next_stop_r, next_stop_nxt;
  logic [1:0]  stop_index_r, stop_index_nxt;
  logic [15:0] pending_r, pending_nxt;

  logic [15:0] col_inc;
  logic        hit;
  logic [2:0]  usable;
  logic [2:0]  idx_inc;
  logic        adv_list;
  logic [16:0] rep_sum;
  logic [15:0] rep_stop;
  logic [15:0] next_a;
  logic [1:0]  idx_a;
  logic [15:0] pend_a;
  logic [15:0] pend_inc;
  logic        first_v;
  res_t        first_r;
  logic        char_v;
  res_t        char_r;

  assign col_inc = (column_r == SAT16) ? SAT16 : column_r + 16'd1;
  assign hit     = (col_inc == next_stop_r);

  always_comb begin
    if (stop_count_r == 3'd0) begin
      usable = 3'd1;
    end else if (stop_count_r > 3'(USABLE_MAX)) begin
      usable = 3'(USABLE_MAX);
    end else begin
      usable = stop_count_r;
    end
  end

  assign idx_inc  = {1'b0, stop_index_r} + 3'd1;
  assign adv_list = (idx_inc < usable);
  assign rep_sum  = {1'b0, next_stop_r} + {9'd0, column_width_r};
  assign rep_stop = rep_sum[16] ? SAT16 : rep_sum[15:0];

  // State after the stop check, before the character itself
  assign next_a   = !hit ? next_stop_r : (adv_list ? stops_r[idx_inc[1:0]] : rep_stop);
  assign idx_a    = (hit && adv_list) ? idx_inc[1:0] : stop_index_r;
  assign pend_a   = hit ? 16'd0 : pending_r;
  assign pend_inc = (pend_a == SAT16) ? SAT16 : pend_a + 16'd1;

  always_comb begin
    column_nxt     = col_inc;
    next_stop_nxt  = next_a;
    stop_index_nxt = idx_a;
    pending_nxt    = 16'd0;
    // stop result, or else the flush of pending spaces
    first_v        = hit && (pending_r != 16'd0);
    first_r.ch     = (pending_r == 16'd1) ? CH_SPACE : CH_TAB;
    first_r.cnt    = 16'd1;
    first_r.last   = 1'b0;
    char_v         = 1'b1;
    char_r.ch      = step_byte;
    char_r.cnt     = 16'd1;
    char_r.last    = 1'b1;
    case (step_byte)
      CH_NL: begin
        column_nxt     = 16'd0;
        stop_index_nxt = 2'd0;
        next_stop_nxt  = stops_r[0];
      end
      CH_SPACE: begin
        pending_nxt = pend_inc;
        char_v      = 1'b0;
      end
      CH_TAB: begin
        column_nxt = (next_a != 16'd0) ? next_a - 16'd1 : 16'd0;
      end
      default: begin
        if (pend_a != 16'd0) begin
          first_v     = 1'b1;
          first_r.ch  = CH_SPACE;
          first_r.cnt = pend_a;
        end
      end
    endcase
  end

  // Compact into slot 0 first, mark the final one
  always_comb begin
    step_res = '0;
    if (first_v) begin
      step_res.r0      = first_r;
      step_res.r0.last = !char_v;
      step_res.r1      = char_r;
      step_res.num     = char_v ? 2'd2 : 2'd1;
    end else begin
      step_res.r0  = char_r;
      step_res.num = char_v ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_width_r <= DEF_COL_WIDTH;
      stop_count_r   <= DEFAULT_STOP_CNT;
      stops_r[0]     <= DEFAULT_STOP_0;
      stops_r[1]     <= DEFAULT_STOP_1;
      stops_r[2]     <= DEFAULT_STOP_2;
      stops_r[3]     <= DEFAULT_STOP_3;
      column_r       <= 16'd0;
      next_stop_r    <= DEFAULT_STOP_0;
      stop_index_r   <= 2'd0;
      pending_r      <= 16'd0;
    end else begin
      if (step_en) begin
        column_r     <= column_nxt;
        next_stop_r  <= next_stop_nxt;
        stop_index_r <= stop_index_nxt;
        pending_r    <= pending_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_COL_WIDTH:  column_width_r <= cfg_wdata[7:0];
          REG_STOP_COUNT: stop_count_r   <= cfg_wdata[2:0];
          REG_STOP_0: begin
            stops_r[0] <= cfg_wdata;
            // at line start the new first stop applies at once
            if (!step_en && column_r == 16'd0 && stop_index_r == 2'd0) begin
              next_stop_r <= cfg_wdata;
            end
          end
          REG_STOP_1:     stops_r[1] <= cfg_wdata;
          REG_STOP_2:     stops_r[2] <= cfg_wdata;
          REG_STOP_3:     stops_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

### sv/ste_outq.sv
// Small result queue taking up to two results per cycle, draining one.
`include "space_to_tab_entab_assert.svh"

module ste_outq
  import ste_pkg::*;
#(
  parameter int DEPTH = OUTQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  res_pair_t push_res,
  output logic      room,
  output logic      head_valid,
  output res_t      head,
  input  logic      pop_en
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_p1;
  logic [1:0]    push_n;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_n     = push_en ? push_res.num : 2'd0;
  assign pop        = pop_en && head_valid;
  assign room       = (count_r <= CW'(DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign wr_ptr_p1  = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_res.r0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `STE_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "result queue count above depth")
  `STE_ASSERT(a_push_room, (push_n != 2'd0) |-> (count_r <= CW'(DEPTH - 2)), "queue overflow")
  `STE_ASSERT(a_head_hold, (head_valid && !pop_en) |=> (head_valid && $stable(head)), "head lost")
  `STE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (count_r == '0), "queue not empty after reset")

endmodule

### sv/space_to_tab_entab.sv
// Top level of the space-to-tab entab stream block.
//
//  channel | dir | transaction fields
//  --------+-----+-----------------------------------------------------------
//  in_     | in  | in_byte
//  out_    | out | out_byte, repeat_count, last (tlast)
//  cfg_    | in  | register index, write data (no handshake, no read-back)
//
// For each accepted input byte the column, stop and pending-space registers
// update at the accepting edge and its zero, one or two results land in a
// small result queue. in_tready stays high while the queue has room for
// two results, so bytes flow one per cycle as long as out_tready keeps up with
// the result count; the queue has a single read port, so the two results of
// one byte leave one at a time. Reset is synchronous and clears all state
// and the configuration registers to their defaults.
module space_to_tab_entab
  import ste_pkg::*;
#(
  parameter int OUTQ_DEPTH_P = OUTQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] repeat_count
  output logic        out_tlast,  // last result caused by an input byte
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic      in_xfer;
  res_pair_t step_res;
  res_t      head;
  logic      room;
  logic      head_valid;

  // Accept a byte only when the queue can hold both possible results
  assign in_tready = room;
  assign in_xfer   = in_tvalid && in_tready;

  ste_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step_en   (in_xfer),
    .step_byte (in_tdata),
    .step_res  (step_res)
  );

  ste_outq #(
    .DEPTH (OUTQ_DEPTH_P)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_xfer),
    .push_res   (step_res),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop_en     (out_tready)
  );

  // Present the queue head; hold it until the sink takes it
  assign out_tvalid = head_valid;
  assign out_tdata  = {head.cnt, head.ch};
  assign out_tlast  = head.last;

endmodule
